### hdl/tfsd_pkg.sv
// shared constants for the tdm frame sample deframer
package tfsd_pkg;

  localparam int unsigned NumChan = 8;
  localparam int unsigned ChanW   = 24;
  localparam int unsigned WordW   = 32;
  localparam int unsigned HistW   = 8;

  // sync history codes, one per word slot of the frame
  localparam logic [HistW-1:0] HistSlot1 = 8'h03;
  localparam logic [HistW-1:0] HistSlot2 = 8'h07;
  localparam logic [HistW-1:0] HistSlot3 = 8'h0f;
  localparam logic [HistW-1:0] HistSlot4 = 8'h1f;
  localparam logic [HistW-1:0] HistSlot5 = 8'h3f;
  localparam logic [HistW-1:0] HistSlot6 = 8'h7f;
  localparam logic [HistW-1:0] HistSlot7 = 8'hff;

  typedef logic [ChanW-1:0] chan_t;

endpackage

### hdl/tdm_frame_sample_deframer_core.sv
// tdm frame deframer: splits 32-bit serial words into eight signed 24-bit channel samples
//
// Each beat carries one received 32-bit word and the frame-sync level sampled with it.
// The level is shifted into an 8-bit sync history; while the history reads 0x03, 0x07,
// 0x0f, 0x1f, 0x3f, 0x7f or 0xff the word is cut into fixed fields and spliced into eight
// 24-bit channel accumulators. When the history reaches 0xff one beat with all eight
// samples leaves on the output channel; with sync held high every further word emits
// again. A word is taken every cycle unless the input stalls. The splice is a single
// level of muxing into the accumulators and the result register, so a beat passes
// the input register, then the result register. The input stalls only while the result
// register is full and stalled and the waiting word would have to advance.
module tdm_frame_sample_deframer_core
  import tfsd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [WordW-1:0]        word_i,
  input  logic                    fsync_level_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ChanW-1:0] chan0_o,
  output logic signed [ChanW-1:0] chan1_o,
  output logic signed [ChanW-1:0] chan2_o,
  output logic signed [ChanW-1:0] chan3_o,
  output logic signed [ChanW-1:0] chan4_o,
  output logic signed [ChanW-1:0] chan5_o,
  output logic signed [ChanW-1:0] chan6_o,
  output logic signed [ChanW-1:0] chan7_o
);

  logic             s1_valid_q;
  logic [WordW-1:0] s1_word_q;
  logic             s1_lvl_q;

  logic [HistW-1:0] hist_q, hist_d;
  chan_t            acc_q [NumChan];
  chan_t            acc_d [NumChan];
  chan_t            res_q [NumChan];
  logic             out_valid_q;

  logic out_free;
  logic advance;
  logic emit;
  logic [WordW-1:0] w;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign w          = s1_word_q;

  // splice the word into the accumulators for the current slot
  always_comb begin
    hist_d = {hist_q[HistW-2:0], s1_lvl_q};
    emit   = 1'b0;
    for (int i = 0; i < NumChan; i++) begin
      acc_d[i] = acc_q[i];
    end
    unique case (hist_d)
      HistSlot1: begin
        acc_d[0] = w[30:7];
        acc_d[1] = {w[6:0], 17'b0};
      end
      HistSlot2: begin
        acc_d[1] = acc_q[1] | {7'b0, w[31:15]};
        acc_d[2] = {w[14:0], 9'b0};
      end
      HistSlot3: begin
        acc_d[2] = acc_q[2] | {15'b0, w[31:23]};
        acc_d[3] = {w[22:0], 1'b0};
      end
      HistSlot4: begin
        acc_d[3] = acc_q[3] | {23'b0, w[31]};
        acc_d[4] = w[30:7];
        acc_d[5] = {w[6:0], 17'b0};
      end
      HistSlot5: begin
        acc_d[5] = acc_q[5] | {7'b0, w[31:15]};
        acc_d[6] = {w[14:0], 9'b0};
      end
      HistSlot6: begin
        acc_d[6] = acc_q[6] | {15'b0, w[31:23]};
        acc_d[7] = {w[22:0], 1'b0};
      end
      HistSlot7: begin
        acc_d[7] = acc_q[7] | {23'b0, w[31]};
        emit     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_q      <= '0;
      for (int i = 0; i < NumChan; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        hist_q <= hist_d;
        for (int i = 0; i < NumChan; i++) begin
          acc_q[i] <= acc_d[i];
        end
      end
      if (out_free) begin
        out_valid_q <= advance && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_word_q <= word_i;
      s1_lvl_q  <= fsync_level_i;
    end
    if (advance && emit) begin
      for (int i = 0; i < NumChan; i++) begin
        res_q[i] <= acc_d[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign chan0_o     = res_q[0];
  assign chan1_o     = res_q[1];
  assign chan2_o     = res_q[2];
  assign chan3_o     = res_q[3];
  assign chan4_o     = res_q[4];
  assign chan5_o     = res_q[5];
  assign chan6_o     = res_q[6];
  assign chan7_o     = res_q[7];

endmodule

### test/tb_tdm_frame_sample_deframer_core.sv
// testbench for the tdm frame sample deframer core: directed and random frames, checked beat by beat
module tb_tdm_frame_sample_deframer_core;
  import tfsd_pkg::*;

  typedef logic [NumChan-1:0][ChanW-1:0] frame_t;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned ItemTarget   = 1200;
  localparam int unsigned IdlePct      = 12;
  localparam int unsigned MaxReports   = 40;

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic [WordW-1:0]        word_i        = '0;
  logic                    fsync_level_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic signed [ChanW-1:0] chan_o [NumChan];

  // predictor state
  logic [HistW-1:0] fs_shift  = '0;
  frame_t           acc_frame = '0;
  frame_t           expected_frames[$];

  bit          no_idle       = 1'b0;
  int unsigned err_count     = 0;
  int unsigned sent_words    = 0;
  int unsigned matched_words = 0;
  int unsigned sent_frames   = 0;
  int unsigned checked_beats = 0;
  int unsigned cycle_count   = 0;

  tdm_frame_sample_deframer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .word_i        (word_i),
    .fsync_level_i (fsync_level_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .chan0_o       (chan_o[0]),
    .chan1_o       (chan_o[1]),
    .chan2_o       (chan_o[2]),
    .chan3_o       (chan_o[3]),
    .chan4_o       (chan_o[4]),
    .chan5_o       (chan_o[5]),
    .chan6_o       (chan_o[6]),
    .chan7_o       (chan_o[7])
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d sample beats still pending", cycle_count,
               expected_frames.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < IdlePct);
  end

  // shift the sync level in and splice the word into the channel accumulators
  task automatic splice_word(input logic [WordW-1:0] w, input logic lvl);
    fs_shift = {fs_shift[HistW-2:0], lvl};
    case (fs_shift)
      HistSlot1: begin
        acc_frame[0] = w[30:7];
        acc_frame[1] = {w[6:0], 17'b0};
      end
      HistSlot2: begin
        acc_frame[1] = acc_frame[1] | {7'b0, w[31:15]};
        acc_frame[2] = {w[14:0], 9'b0};
      end
      HistSlot3: begin
        acc_frame[2] = acc_frame[2] | {15'b0, w[31:23]};
        acc_frame[3] = {w[22:0], 1'b0};
      end
      HistSlot4: begin
        acc_frame[3] = acc_frame[3] | {23'b0, w[31]};
        acc_frame[4] = w[30:7];
        acc_frame[5] = {w[6:0], 17'b0};
      end
      HistSlot5: begin
        acc_frame[5] = acc_frame[5] | {7'b0, w[31:15]};
        acc_frame[6] = {w[14:0], 9'b0};
      end
      HistSlot6: begin
        acc_frame[6] = acc_frame[6] | {15'b0, w[31:23]};
        acc_frame[7] = {w[22:0], 1'b0};
      end
      HistSlot7: begin
        acc_frame[7] = acc_frame[7] | {23'b0, w[31]};
        expected_frames.push_back(acc_frame);
      end
      default: ;
    endcase
    if (fs_shift inside {HistSlot1, HistSlot2, HistSlot3, HistSlot4, HistSlot5, HistSlot6,
                         HistSlot7}) begin
      matched_words++;
    end
  endtask

  // one input beat, with a random idle cycle ahead of it
  task automatic send_word(input logic [WordW-1:0] w, input logic lvl);
    if (!no_idle && ($urandom_range(0, 99) < IdlePct)) begin
      in_valid_i <= 1'b0;
      word_i     <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    word_i        <= w;
    fsync_level_i <= lvl;
    do @(posedge clk_i); while (in_stall_o);
    splice_word(w, lvl);
    sent_words++;
  endtask

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_run(input logic lvl, input int unsigned count);
    repeat (count) send_word(rand_word(), lvl);
  endtask

  always @(posedge clk_i) begin : check_beats
    frame_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frames.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports) begin
          $display("%0t: unexpected sample beat, expected none, got chan0 %h", $time,
                   chan_o[0]);
        end
      end else begin
        want = expected_frames.pop_front();
        checked_beats++;
        for (int c = 0; c < NumChan; c++) begin
          if (chan_o[c] !== want[c]) begin
            err_count++;
            if (err_count <= MaxReports) begin
              $display("%0t: chan%0d mismatch, expected %h, got %h", $time, c, want[c],
                       chan_o[c]);
            end
          end
        end
      end
    end
  end

  // from reset the history is clear, so eight high words make one full frame
  task automatic test_full_scale_frame();
    repeat (HistW) send_word('1, 1'b1);
    sent_frames++;
  endtask

  task automatic test_sync_held_high();
    send_word('0, 1'b1);
    send_word(32'h8000_0000, 1'b1);
  endtask

  // two low words after a full history leave ones above them: the frame starts mid-way
  task automatic test_partial_frame();
    send_word(32'h5555_5555, 1'b0);
    send_word(32'haaaa_aaaa, 1'b0);
    repeat (HistW) send_word('0, 1'b1);
  endtask

  task automatic test_random_frames();
    int unsigned kind;
    int unsigned frame_idx;
    frame_idx = 0;
    while (sent_words < ItemTarget) begin
      no_idle = (frame_idx >= 40) && (frame_idx < 60);
      kind    = $urandom_range(0, 99);
      if (kind < 80) begin
        send_run(1'b0, 6 + $urandom_range(0, 2));
        send_run(1'b1, HistW);
        if ($urandom_range(0, 3) == 0) send_run(1'b1, $urandom_range(1, 3));
        sent_frames++;
      end else if (kind < 90) begin
        // sync low too briefly or dropped early
        send_run(1'b0, $urandom_range(1, 5));
        send_run(1'b1, $urandom_range(1, 10));
      end else begin
        repeat ($urandom_range(4, 12)) send_word(rand_word(), 1'($urandom));
      end
      frame_idx++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_scale_frame();
    test_sync_held_high();
    test_partial_frame();
    test_random_frames();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("sent %0d words (%0d on a sync slot), %0d aligned frames", sent_words,
             matched_words, sent_frames);
    $display("checked %0d sample beats, %0d mismatches", checked_beats, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
hdl/tfsd_pkg.sv
hdl/tdm_frame_sample_deframer_core.sv
test/tb_tdm_frame_sample_deframer_core.sv
